/* hw/rtl/spb_pkg.sv */
`timescale 1ns / 1ps
// Package for the sorted position buffer: sizes, operation and status codes,
// sequencer states. No dependencies.
package spb_pkg;

    localparam int CAPACITY      = 64;
    localparam int POSITION_BITS = 32;

    // Key width actually stored: the position field carries 32 bits
    localparam int KEY_W  = (POSITION_BITS < 32) ? POSITION_BITS : 32;
    localparam int PAY_W  = 32;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ENT_W  = KEY_W + PAY_W;
    localparam int CFG_W  = 7;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_HEAD   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_CAP,
        S_SCAN,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_INSERT,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/sorted_position_buffer.sv */
`timescale 1ns / 1ps
// Top level of the sorted position buffer: sequencer, entry RAM, output register.
// Depends on spb_pkg and spb_ram.
//
//  channel   dir   handshake              payload
//  s_        in    s_valid / s_ready      s_operation, s_position, s_payload_in
//  m_        out   m_valid / m_ready      m_status, m_payload_out, m_evicted_valid,
//                                         m_evicted_payload, m_entry_total
//  cfg_      in    cfg_valid / cfg_ready  cfg_data (capacity_limit)
//
// Walk: every transfer but remove head on an empty store walks the entry RAM, one
//   read per cycle on its single read port.
// Reset: synchronous, active low; the entry count clears and the limit returns to 64.
//   The RAM is not cleared: slots at or above the count are never read.
// Stalls: s_ready is high only between operations; a finished result waits in the
//   output register while the next transfer is taken. cfg_ready is always high.
module sorted_position_buffer
    import spb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    input  logic [31:0]          s_position,
    input  logic [31:0]          s_payload_in,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [31:0]          m_payload_out,
    output logic                 m_evicted_valid,
    output logic [31:0]          m_evicted_payload,
    output logic [6:0]           m_entry_total,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Sequencer state and working registers
    state_t              state_reg,   state_next;
    op_t                 op_reg,      op_next;
    logic [KEY_W-1:0]    key_reg,     key_next;
    logic [PAY_W-1:0]    pay_reg,     pay_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [CNT_W-1:0]    p_reg,       p_next;      // walk pointer
    logic                pend_reg,    pend_next;   // a RAM read is in flight
    logic [AW-1:0]       wa_reg,      wa_next;     // write target of that read
    logic [AW-1:0]       ci_reg,      ci_next;     // index of that read
    logic [CNT_W-1:0]    at_reg,      at_next;     // insert slot
    status_t             status_reg,  status_next;
    logic [PAY_W-1:0]    found_reg,   found_next;
    logic                ev_valid_reg, ev_valid_next;
    logic [PAY_W-1:0]    ev_pay_reg,  ev_pay_next;
    logic [CFG_W-1:0]    cap_reg;

    // Output register
    logic                m_valid_reg,   m_valid_next;
    status_t             m_status_reg,  m_status_next;
    logic [PAY_W-1:0]    m_pay_reg,     m_pay_next;
    logic                m_ev_v_reg,    m_ev_v_next;
    logic [PAY_W-1:0]    m_ev_pay_reg,  m_ev_pay_next;
    logic [CNT_W-1:0]    m_total_reg,   m_total_next;

    // RAM port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENT_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENT_W-1:0]    ram_rdata;
    logic [KEY_W-1:0]    rd_key;
    logic [PAY_W-1:0]    rd_pay;

    logic [CNT_W-1:0]    eff_lim;
    logic                hit_eq, hit_gt;

    spb_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[ENT_W-1:PAY_W];
    assign rd_pay = ram_rdata[PAY_W-1:0];

    // Limit of zero acts as one; above the store size acts as the store size
    always_comb begin
        if (cap_reg == '0) begin
            eff_lim = CNT_W'(1);
        end else if (32'(cap_reg) > CAPACITY) begin
            eff_lim = CNT_W'(CAPACITY);
        end else begin
            eff_lim = CNT_W'(cap_reg);
        end
    end

    // Compare the entry that arrived from the RAM this cycle
    assign hit_eq = pend_reg && (rd_key == key_reg);
    assign hit_gt = pend_reg && (rd_key > key_reg) && (op_reg == OP_PUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            cap_reg     <= CFG_W'(64);
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
        op_reg       <= op_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        p_reg        <= p_next;
        wa_reg       <= wa_next;
        ci_reg       <= ci_next;
        at_reg       <= at_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        ev_valid_reg <= ev_valid_next;
        ev_pay_reg   <= ev_pay_next;
        m_status_reg <= m_status_next;
        m_pay_reg    <= m_pay_next;
        m_ev_v_reg   <= m_ev_v_next;
        m_ev_pay_reg <= m_ev_pay_next;
        m_total_reg  <= m_total_next;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        count_next    = count_reg;
        p_next        = p_reg;
        pend_next     = pend_reg;
        wa_next       = wa_reg;
        ci_next       = ci_reg;
        at_next       = at_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        ev_valid_next = ev_valid_reg;
        ev_pay_next   = ev_pay_reg;

        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_pay_next    = m_pay_reg;
        m_ev_v_next   = m_ev_v_reg;
        m_ev_pay_next = m_ev_pay_reg;
        m_total_next  = m_total_reg;

        ram_we    = 1'b0;
        ram_waddr = wa_reg;
        ram_wdata = ram_rdata;
        ram_raddr = '0;

        // Drop the held result once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next       = op_t'(s_operation);
                    key_next      = s_position[KEY_W-1:0];
                    pay_next      = s_payload_in;
                    status_next   = ST_DONE;
                    found_next    = '0;
                    ev_valid_next = 1'b0;
                    ev_pay_next   = '0;
                    p_next        = '0;
                    pend_next     = 1'b0;
                    unique case (op_t'(s_operation))
                        OP_PUT: begin
                            if ((count_reg >= eff_lim) && (count_reg != '0)) begin
                                ev_valid_next = 1'b1;
                                state_next    = S_HEAD_RD;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_GET, OP_REMOVE: begin
                            state_next = S_SCAN;
                        end
                        OP_HEAD: begin
                            if (count_reg != '0) begin
                                state_next = S_HEAD_RD;
                            end else begin
                                status_next = ST_MISS;
                                state_next  = S_DONE;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_HEAD_RD: begin
                ram_raddr  = '0;
                state_next = S_HEAD_CAP;
            end

            S_HEAD_CAP: begin
                if (op_reg == OP_PUT) begin
                    ev_pay_next = rd_pay;
                end else begin
                    found_next = rd_pay;
                end
                p_next     = '0;
                pend_next  = 1'b0;
                state_next = S_SHIFT_DN;
            end

            S_SCAN: begin
                if (hit_eq || hit_gt) begin
                    pend_next = 1'b0;
                    unique case (op_reg)
                        OP_PUT: begin
                            if (hit_eq) begin
                                status_next = ST_DUP;
                                state_next  = S_DONE;
                            end else begin
                                at_next    = CNT_W'(ci_reg);
                                p_next     = count_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_REMOVE: begin
                            found_next = rd_pay;
                            p_next     = CNT_W'(ci_reg);
                            state_next = S_SHIFT_DN;
                        end
                        default: begin
                            found_next = rd_pay;
                            state_next = S_DONE;
                        end
                    endcase
                end else if (p_reg < count_reg) begin
                    ram_raddr = p_reg[AW-1:0];
                    pend_next = 1'b1;
                    ci_next   = p_reg[AW-1:0];
                    p_next    = p_reg + CNT_W'(1);
                end else begin
                    // Walk exhausted without a match
                    pend_next = 1'b0;
                    if (op_reg == OP_PUT) begin
                        if (32'(count_reg) < CAPACITY) begin
                            at_next    = count_reg;
                            p_next     = count_reg;
                            state_next = S_SHIFT_UP;
                        end else begin
                            state_next = S_DONE;
                        end
                    end else begin
                        status_next = ST_MISS;
                        state_next  = S_DONE;
                    end
                end
            end

            S_SHIFT_DN: begin
                // Close the gap at p: slot j takes slot j+1
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg;
                    ram_wdata = ram_rdata;
                end
                if (({1'b0, p_reg} + (CNT_W + 1)'(1)) < {1'b0, count_reg}) begin
                    ram_raddr = AW'(p_reg + CNT_W'(1));
                    wa_next   = p_reg[AW-1:0];
                    pend_next = 1'b1;
                    p_next    = p_reg + CNT_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                    p_next     = '0;
                    if (op_reg == OP_PUT) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SHIFT_UP: begin
                // Open a gap at the insert slot: slot i takes slot i-1
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg;
                    ram_wdata = ram_rdata;
                end
                if (p_reg > at_reg) begin
                    ram_raddr = AW'(p_reg - CNT_W'(1));
                    wa_next   = p_reg[AW-1:0];
                    pend_next = 1'b1;
                    p_next    = p_reg - CNT_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_INSERT;
                end
            end

            S_INSERT: begin
                ram_we     = 1'b1;
                ram_waddr  = at_reg[AW-1:0];
                ram_wdata  = {key_reg, pay_reg};
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_pay_next    = found_reg;
                    m_ev_v_next   = ev_valid_reg;
                    m_ev_pay_next = ev_pay_reg;
                    m_total_next  = count_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready           = (state_reg == S_IDLE);
    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_payload_out     = m_pay_reg;
    assign m_evicted_valid   = m_ev_v_reg;
    assign m_evicted_payload = m_ev_pay_reg;
    assign m_entry_total     = 7'(m_total_reg);

    // The count never passes the store size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= CAPACITY)
        else $error("entry count above store size");

    // The count moves by at most one per cycle
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1))
        || (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count jumped");

    // A transfer closes the input until its walk is over
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input open during an operation");

    // Shift writes never hit the slot being read in the same cycle
    a_shift_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && pend_next && (state_reg == S_SHIFT_DN || state_reg == S_SHIFT_UP))
        |-> (ram_waddr != ram_raddr))
        else $error("shift read and write collide");

    // An eviction is never reported with a miss
    a_evict_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_evicted_valid) |-> (m_status != ST_MISS))
        else $error("eviction reported with miss");

endmodule

/* hw/rtl/spb_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
